// ===== hdl/calendar_day_difference_core_assert.svh =====
// Assertion macros for the date difference core.
// CDD_ASSERT checks a property with reset masking; CDD_ASSERT_NR checks it at every edge.
`ifndef CALENDAR_DAY_DIFFERENCE_CORE_ASSERT_SVH
`define CALENDAR_DAY_DIFFERENCE_CORE_ASSERT_SVH
`ifndef SYNTH
`define CDD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CDD_ASSERT_NR(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CDD_ASSERT(lbl, clk, rst, prop, msg)
`define CDD_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

// ===== hdl/cdd_pkg.sv =====
package cdd_pkg;

   localparam int DAY_W  = 5;
   localparam int MON_W  = 4;
   localparam int YEAR_W = 14;
   localparam int DN_W   = 23;   // day number since 0000-01-01, up to year 16383
   localparam int DAYS_W = 22;
   localparam int Q100_W = 8;    // year / 100 for a 14-bit year
   localparam int CORR_W = 13;   // leap day correction p/4 - p/100 + p/400

   localparam int MAX_YEAR = 9999;

   localparam logic [DAYS_W-1:0] DAYS_MAX = '1;

   // year / 100 == (year * 5243) >> 19, exact for 14-bit years
   localparam int RECIP_100   = 5243;
   localparam int RECIP_SHIFT = 19;
   localparam int RECIP_W     = YEAR_W + 13;

   localparam logic [MON_W-1:0] MON_JAN = 4'd1;
   localparam logic [MON_W-1:0] MON_FEB = 4'd2;
   localparam logic [MON_W-1:0] MON_DEC = 4'd12;

   typedef enum logic [1:0] {
      ORD_EQUAL   = 2'b00,
      ORD_LATER   = 2'b01,
      ORD_EARLIER = 2'b11
   } order_type;

   // per-stage advance strobes for the day-number pipe
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
   } stage_en_type;

   function automatic logic [8:0] days_before(input logic [MON_W-1:0] mon);
      logic [8:0] r;
      case (mon)
         4'd2:    r = 9'd31;
         4'd3:    r = 9'd59;
         4'd4:    r = 9'd90;
         4'd5:    r = 9'd120;
         4'd6:    r = 9'd151;
         4'd7:    r = 9'd181;
         4'd8:    r = 9'd212;
         4'd9:    r = 9'd243;
         4'd10:   r = 9'd273;
         4'd11:   r = 9'd304;
         4'd12:   r = 9'd334;
         default: r = 9'd0;
      endcase
      return r;
   endfunction

   function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] mon,
                                                  input logic leap);
      logic [DAY_W-1:0] r;
      case (mon)
         4'd2:    r = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
         default: r = 5'd31;
      endcase
      return r;
   endfunction

endpackage

// ===== hdl/cdd_day_number.sv =====
module cdd_day_number #(
   parameter int MAX_YEAR = cdd_pkg::MAX_YEAR
) (
   input  logic                       clock,
   input  cdd_pkg::stage_en_type      en,
   input  logic [cdd_pkg::DAY_W-1:0]  day,
   input  logic [cdd_pkg::MON_W-1:0]  month,
   input  logic [cdd_pkg::YEAR_W-1:0] year,
   output logic [cdd_pkg::DN_W-1:0]   day_num,
   output logic                       date_ok
);
   import cdd_pkg::*;

   // stage 1: reciprocal multiplies for year/100 and (year-1)/100
   logic [DAY_W-1:0]   day_s1_ff;
   logic [MON_W-1:0]   mon_s1_ff;
   logic [YEAR_W-1:0]  year_s1_ff;
   logic [Q100_W-1:0]  q100y_s1_ff, q100y_s1_in;
   logic [Q100_W-1:0]  q100p_s1_ff, q100p_s1_in;
   logic [YEAR_W-1:0]  prev_year;
   logic [RECIP_W-1:0] prod_y, prod_p;

   assign prev_year   = year - YEAR_W'(1);
   assign prod_y      = RECIP_W'(year) * RECIP_W'(RECIP_100);
   assign prod_p      = RECIP_W'(prev_year) * RECIP_W'(RECIP_100);
   assign q100y_s1_in = Q100_W'(prod_y >> RECIP_SHIFT);
   assign q100p_s1_in = Q100_W'(prod_p >> RECIP_SHIFT);

   always_ff @(posedge clock) begin
      if (en.s1) begin
         day_s1_ff   <= day;
         mon_s1_ff   <= month;
         year_s1_ff  <= year;
         q100y_s1_ff <= q100y_s1_in;
         q100p_s1_ff <= q100p_s1_in;
      end
   end

   // stage 2: leap flag, 365*year and leap correction
   logic [DAY_W-1:0]  day_s2_ff;
   logic [MON_W-1:0]  mon_s2_ff;
   logic [DN_W-1:0]   base_s2_ff, base_s2_in;
   logic [CORR_W-1:0] corr_s2_ff, corr_s2_in;
   logic              leap_s2_ff, leap_s2_in;
   logic              yok_s2_ff, yok_s2_in;
   logic [YEAR_W-1:0] rem100, prev_s1;
   logic              year_zero;

   assign year_zero = (year_s1_ff == '0);
   assign prev_s1   = year_s1_ff - YEAR_W'(1);
   assign rem100    = year_s1_ff - (YEAR_W'(q100y_s1_ff) * YEAR_W'(100));
   assign leap_s2_in = ((year_s1_ff[1:0] == 2'b00) && (rem100 != '0)) ||
                       ((rem100 == '0) && (q100y_s1_ff[1:0] == 2'b00));
   assign base_s2_in = year_zero ? '0 :
                       DN_W'(DN_W'(year_s1_ff) * DN_W'(365) + DN_W'(1));
   assign corr_s2_in = year_zero ? '0 :
                       CORR_W'(prev_s1 >> 2) + CORR_W'(q100p_s1_ff >> 2)
                       - CORR_W'(q100p_s1_ff);
   assign yok_s2_in  = ({2'b00, year_s1_ff} <= 16'(MAX_YEAR));

   always_ff @(posedge clock) begin
      if (en.s2) begin
         day_s2_ff  <= day_s1_ff;
         mon_s2_ff  <= mon_s1_ff;
         base_s2_ff <= base_s2_in;
         corr_s2_ff <= corr_s2_in;
         leap_s2_ff <= leap_s2_in;
         yok_s2_ff  <= yok_s2_in;
      end
   end

   // stage 3: final sum and range check of day and month
   logic [DN_W-1:0] day_num_ff, day_num_in;
   logic            date_ok_ff, date_ok_in;
   logic            mon_ok, leap_add;

   assign mon_ok   = (mon_s2_ff >= MON_JAN) && (mon_s2_ff <= MON_DEC);
   assign leap_add = (mon_s2_ff > MON_FEB) && leap_s2_ff;
   assign date_ok_in = mon_ok && yok_s2_ff && (day_s2_ff != '0) &&
                       (day_s2_ff <= month_len(mon_s2_ff, leap_s2_ff));
   assign day_num_in = base_s2_ff + DN_W'(corr_s2_ff) + DN_W'(days_before(mon_s2_ff))
                       + DN_W'(leap_add) + DN_W'(day_s2_ff) - DN_W'(1);

   always_ff @(posedge clock) begin
      if (en.s3) begin
         day_num_ff <= day_num_in;
         date_ok_ff <= date_ok_in;
      end
   end

   assign day_num = day_num_ff;
   assign date_ok = date_ok_ff;

endmodule

// ===== hdl/calendar_day_difference_core.sv =====
// Gregorian date difference core. Each input transaction carries two dates
// (day, month, year); each output transaction gives the absolute number of days
// between them (zero unless both are valid, saturating at the 22-bit maximum),
// their order (year, then month, then day, compared on the raw fields), and a
// validity flag per date. Years 0 to MAX_YEAR are accepted, year 0 being a leap
// year. The core is a four-stage pipeline: a transaction can enter every cycle
// unless back-pressure has filled every stage. The stages are the reciprocal
// multiply for year/100, the 365*year product with the leap flag and leap
// correction, the day-number sum with the range check, and the final subtract
// and saturate in the output register. Each stage holds its contents while the
// one after it is full and stalled, so empty stages still fill under
// back-pressure and no transaction is dropped or repeated.
`include "calendar_day_difference_core_assert.svh"

module calendar_day_difference_core #(
   parameter int MAX_YEAR = cdd_pkg::MAX_YEAR
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [4:0] first_day, [8:5] first_month, [22:9] first_year,
   // [27:23] second_day, [31:28] second_month, [45:32] second_year, [47:46] zero
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [21:0] days_apart, [23:22] order, [24] first_valid, [25] second_valid,
   // [31:26] zero
   output logic [31:0] rsp_tdata
);
   import cdd_pkg::*;

   // unpack request
   logic [DAY_W-1:0]  first_day, second_day;
   logic [MON_W-1:0]  first_month, second_month;
   logic [YEAR_W-1:0] first_year, second_year;

   assign first_day    = req_tdata[4:0];
   assign first_month  = req_tdata[8:5];
   assign first_year   = req_tdata[22:9];
   assign second_day   = req_tdata[27:23];
   assign second_month = req_tdata[31:28];
   assign second_year  = req_tdata[45:32];

   // stage valids and advance strobes; a stage moves when empty or when the next moves
   logic         v1_ff, v2_ff, v3_ff, vo_ff;
   logic         en_o;
   stage_en_type en;

   assign en_o  = !vo_ff || rsp_tready;
   assign en.s3 = !v3_ff || en_o;
   assign en.s2 = !v2_ff || en.s3;
   assign en.s1 = !v1_ff || en.s2;
   assign req_tready = en.s1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         if (en.s1) v1_ff <= req_tvalid;
         if (en.s2) v2_ff <= v1_ff;
         if (en.s3) v3_ff <= v2_ff;
         if (en_o)  vo_ff <= v3_ff;
      end
   end

   // order on the raw fields, carried alongside the day-number pipe
   logic [22:0] key_first, key_second;
   order_type   ord_s1_ff, ord_s1_in, ord_s2_ff, ord_s3_ff;

   assign key_first  = {first_year, first_month, first_day};
   assign key_second = {second_year, second_month, second_day};
   assign ord_s1_in  = (key_first > key_second) ? ORD_LATER :
                       (key_first < key_second) ? ORD_EARLIER : ORD_EQUAL;

   always_ff @(posedge clock) begin
      if (en.s1) ord_s1_ff <= ord_s1_in;
      if (en.s2) ord_s2_ff <= ord_s1_ff;
      if (en.s3) ord_s3_ff <= ord_s2_ff;
   end

   // day numbers of both dates
   logic [DN_W-1:0] dn_first, dn_second;
   logic            ok_first, ok_second;

   cdd_day_number #(
      .MAX_YEAR (MAX_YEAR)
   ) u_first (
      .clock   (clock),
      .en      (en),
      .day     (first_day),
      .month   (first_month),
      .year    (first_year),
      .day_num (dn_first),
      .date_ok (ok_first)
   );

   cdd_day_number #(
      .MAX_YEAR (MAX_YEAR)
   ) u_second (
      .clock   (clock),
      .en      (en),
      .day     (second_day),
      .month   (second_month),
      .year    (second_year),
      .day_num (dn_second),
      .date_ok (ok_second)
   );

   // output stage: absolute difference, saturated
   logic [DN_W-1:0]   diff;
   logic [DAYS_W-1:0] days_ff, days_in;
   order_type         ord_o_ff;
   logic              fv_ff, sv_ff;

   assign diff    = (dn_first > dn_second) ? (dn_first - dn_second)
                                           : (dn_second - dn_first);
   assign days_in = !(ok_first && ok_second) ? '0 :
                    diff[DN_W-1] ? DAYS_MAX : diff[DAYS_W-1:0];

   always_ff @(posedge clock) begin
      if (en_o) begin
         days_ff  <= days_in;
         ord_o_ff <= ord_s3_ff;
         fv_ff    <= ok_first;
         sv_ff    <= ok_second;
      end
   end

   assign rsp_tvalid = vo_ff;
   assign rsp_tdata  = {6'b000000, sv_ff, fv_ff, ord_o_ff, days_ff};

   // checks
   `CDD_ASSERT(a_days_need_valid, clock, reset, (vo_ff && (days_ff != '0)) |-> (fv_ff && sv_ff), "nonzero day count with an invalid date")
   `CDD_ASSERT(a_equal_zero_days, clock, reset, (vo_ff && (ord_o_ff == ORD_EQUAL)) |-> (days_ff == '0), "equal dates with nonzero day count")
   `CDD_ASSERT(a_accept_fills_s1, clock, reset, (req_tvalid && req_tready) |=> v1_ff, "accepted transaction not captured in first stage")
   `CDD_ASSERT(a_stall_holds_s3, clock, reset, (v3_ff && !en_o) |=> v3_ff, "stalled transaction lost from third stage")

endmodule

// ===== sim/calendar_day_difference_core_test.sv =====
module calendar_day_difference_core_test;
   import cdd_pkg::*;

   localparam int RANDOM_PAIRS = 1500;
   localparam int CALM_TAIL    = 150;   // last pairs sent with no idling on either side
   localparam int LONG_HOLD    = 60;    // cycles the receiver blocks to back the pipe up

   // one date as it sits in the request word: day in the lowest bits
   typedef struct packed {
      logic [YEAR_W-1:0] year;
      logic [MON_W-1:0]  month;
      logic [DAY_W-1:0]  day;
   } cal_date_type;

   // the response word below its zero padding, days_apart in the lowest bits
   typedef struct packed {
      logic              second_valid;
      logic              first_valid;
      order_type         order;
      logic [DAYS_W-1:0] days_apart;
   } date_span_type;

   // Works out the span, order and validity of each accepted pair of dates and
   // checks the responses against them in arrival order.
   class date_span_scoreboard;
      date_span_type expected_q[$];
      int unsigned   failures;

      function new();
         failures = 0;
      endfunction

      function bit leap_year(int unsigned y);
         return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
      endfunction

      function int unsigned days_in_month(int unsigned m, int unsigned y);
         if (m == MON_FEB) return leap_year(y) ? 29 : 28;
         if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
         return 31;
      endfunction

      function bit date_is_real(cal_date_type d);
         if (d.month < MON_JAN || d.month > MON_DEC || d.year > MAX_YEAR) return 1'b0;
         return d.day >= 1 && d.day <= days_in_month(d.month, d.year);
      endfunction

      // days elapsed since 1 January of year 0 (itself a leap year)
      function longint unsigned day_ordinal(cal_date_type d);
         longint unsigned n;
         longint unsigned p;
         n = 0;
         if (d.year > 0) begin
            p = d.year - 1;
            n = 365 * d.year + 1 + p / 4 - p / 100 + p / 400;
         end
         for (int k = MON_JAN; k < d.month; k++) n += days_in_month(k, d.year);
         return n + d.day - 1;
      endfunction

      // raw field comparison, valid or not
      function order_type date_order(cal_date_type a, cal_date_type b);
         if (a.year != b.year) begin
            if (a.year > b.year) return ORD_LATER;
            return ORD_EARLIER;
         end
         if (a.month != b.month) begin
            if (a.month > b.month) return ORD_LATER;
            return ORD_EARLIER;
         end
         if (a.day != b.day) begin
            if (a.day > b.day) return ORD_LATER;
            return ORD_EARLIER;
         end
         return ORD_EQUAL;
      endfunction

      function date_span_type span_between(cal_date_type a, cal_date_type b);
         date_span_type   r;
         longint unsigned na;
         longint unsigned nb;
         longint unsigned span;
         r.first_valid  = date_is_real(a);
         r.second_valid = date_is_real(b);
         r.order        = date_order(a, b);
         span = 0;
         if (r.first_valid && r.second_valid) begin
            na   = day_ordinal(a);
            nb   = day_ordinal(b);
            span = (na > nb) ? na - nb : nb - na;
            if (span > DAYS_MAX) span = DAYS_MAX;
         end
         r.days_apart = span[DAYS_W-1:0];
         return r;
      endfunction

      function void note_request(logic [47:0] word);
         cal_date_type a;
         cal_date_type b;
         a = word[22:0];
         b = word[45:23];
         expected_q.push_back(span_between(a, b));
      endfunction

      function void check_response(logic [31:0] word);
         date_span_type got;
         date_span_type want;
         got = word[25:0];
         if (expected_q.size() == 0) begin
            failures++;
            $display("%0t: response with nothing outstanding, expected none, got %h",
                     $time, word);
            return;
         end
         want = expected_q.pop_front();
         if (got.days_apart !== want.days_apart) begin
            failures++;
            $display("%0t: days_apart expected %0d, got %0d",
                     $time, want.days_apart, got.days_apart);
         end
         if (got.order !== want.order) begin
            failures++;
            $display("%0t: order expected %b, got %b", $time, want.order, got.order);
         end
         if (got.first_valid !== want.first_valid) begin
            failures++;
            $display("%0t: first_valid expected %b, got %b",
                     $time, want.first_valid, got.first_valid);
         end
         if (got.second_valid !== want.second_valid) begin
            failures++;
            $display("%0t: second_valid expected %b, got %b",
                     $time, want.second_valid, got.second_valid);
         end
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;

   bit calm;            // no idling on either side
   bit long_hold_due;   // asks the receiver for one long stall

   date_span_scoreboard sb;

   calendar_day_difference_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // both handshakes are observed at the edge, before any new drive takes effect
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_request(req_tdata);
         if (rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
      end
   end

   // receiver: open stretches, short random stalls, and one long hold-off
   initial begin
      forever begin
         if (long_hold_due) begin
            long_hold_due = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (!calm && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   initial begin
      #2000000;
      $display("** calendar_day_difference_core: FAILED **");
      $finish;
   end

   function automatic cal_date_type civil(int unsigned d, int unsigned m, int unsigned y);
      cal_date_type r;
      r.day   = DAY_W'(d);
      r.month = MON_W'(m);
      r.year  = YEAR_W'(y);
      return r;
   endfunction

   // any field values at all, mostly not a real date
   function automatic cal_date_type any_date();
      return civil($urandom_range(0, 31), $urandom_range(0, 15), $urandom_range(0, 16383));
   endfunction

   function automatic cal_date_type real_date_in(int unsigned y);
      int unsigned m;
      m = $urandom_range(MON_JAN, MON_DEC);
      return civil($urandom_range(1, sb.days_in_month(m, y)), m, y);
   endfunction

   function automatic int unsigned pick_year();
      case ($urandom_range(0, 5))
         0:       return $urandom_range(0, 4);           // around year zero
         1:       return $urandom_range(1895, 2105);     // century boundaries
         2:       return $urandom_range(MAX_YEAR - 4, MAX_YEAR);
         default: return $urandom_range(0, MAX_YEAR);
      endcase
   endfunction

   task automatic pause_requests();
      req_tvalid <= 1'b0;
      req_tdata  <= 48'({$urandom, $urandom});   // junk while nothing is offered
      repeat ($urandom_range(1, 5)) @(posedge clock);
   endtask

   // offers one transaction and returns at the edge that accepts it
   task automatic offer_dates(cal_date_type a, cal_date_type b);
      if (!calm && $urandom_range(0, 4) == 0) pause_requests();
      req_tdata  <= {2'b00, b, a};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic offer_random_pair();
      cal_date_type a;
      cal_date_type b;
      a = ($urandom_range(0, 6) == 0) ? any_date() : real_date_in(pick_year());
      case ($urandom_range(0, 9))
         0, 1, 2, 3: b = real_date_in(pick_year());
         4, 5, 6:    b = real_date_in(a.year);
         7, 8: begin
            b = a;
            b.day = DAY_W'($urandom_range(1, 31));
         end
         default:    b = a;
      endcase
      if ($urandom_range(0, 7) == 0) b = any_date();
      offer_dates(a, b);
   endtask

   initial begin
      sb = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // field extremes and the calendar corner cases
      offer_dates(civil(0, 0, 0), civil(0, 0, 0));
      offer_dates(civil(31, 15, 16383), civil(31, 15, 16383));
      offer_dates(civil(1, 1, 0), civil(31, 12, MAX_YEAR));       // widest span
      offer_dates(civil(31, 12, MAX_YEAR), civil(1, 1, 0));
      offer_dates(civil(29, 2, 0), civil(1, 3, 0));               // year zero is leap
      offer_dates(civil(29, 2, 2000), civil(28, 2, 2000));
      offer_dates(civil(29, 2, 1900), civil(1, 3, 1900));         // century, not leap
      offer_dates(civil(29, 2, 2024), civil(29, 2, 2023));
      offer_dates(civil(1, 3, 2100), civil(28, 2, 2100));
      offer_dates(civil(1, 3, 2400), civil(28, 2, 2400));
      offer_dates(civil(31, 4, 2021), civil(30, 4, 2021));        // day past month end
      offer_dates(civil(31, 8, 1999), civil(31, 9, 1999));
      offer_dates(civil(0, 5, 2021), civil(1, 5, 2021));          // day zero
      offer_dates(civil(15, 13, 2021), civil(15, 12, 2021));      // month out of range
      offer_dates(civil(15, 0, 2021), civil(15, 1, 2021));
      offer_dates(civil(1, 1, MAX_YEAR + 1), civil(31, 12, MAX_YEAR));
      offer_dates(civil(31, 12, MAX_YEAR), civil(31, 12, MAX_YEAR));
      offer_dates(civil(31, 12, 2023), civil(1, 1, 2024));
      offer_dates(civil(10, 6, 1500), civil(20, 6, 1500));        // ordered by day
      offer_dates(civil(10, 7, 1500), civil(10, 3, 1500));        // ordered by month
      offer_dates(civil(31, 1, 8191), civil(1, 2, 8192));
      offer_dates(civil(20, 15, 16383), civil(5, 0, 0));          // invalid, still ordered

      for (int k = 0; k < RANDOM_PAIRS; k++) begin
         if (k == 300) long_hold_due = 1'b1;
         if (k == RANDOM_PAIRS - CALM_TAIL) calm = 1'b1;
         offer_random_pair();
      end
      req_tvalid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);   // catch any stray response from the pipe
      if (sb.failures == 0) begin
         $display("** calendar_day_difference_core: PASSED **");
      end else begin
         $display("** calendar_day_difference_core: FAILED **");
      end
      $finish;
   end

endmodule
